// ----- hdl/pvs_pkg.sv -----
package pvs_pkg;

  localparam int PARTICLES_DEF = 256;
  localparam int FRAMES_DEF    = 4;

  // Field widths of the ports.
  localparam int BOX_W   = 31;
  localparam int COORD_W = 32;
  localparam int IDX_W   = 8;
  localparam int SLOT_W  = 2;

  localparam logic [BOX_W-1:0] BOX_RESET = 31'd655360;

  // Internal datapath widths.
  localparam int VW       = COORD_W + 1;  // coordinate difference
  localparam int DW       = VW + 2;       // folded separation, signed
  localparam int UW       = DW - 1;       // folded separation magnitude
  localparam int NW       = 30;           // normalized separation, signed
  localparam int NMW      = NW - 1;       // normalized separation magnitude
  localparam int NORM_MSB = NMW - 1;      // leading one of the largest magnitude
  localparam int SH_W     = 5;
  localparam int QW       = 2 * NMW + 2;  // sum of three squares
  localparam int RW       = QW / 2;       // root
  localparam int PW       = VW + NW + 2;  // dot product, signed
  localparam int NUM_W    = 64;           // dividend magnitude
  localparam int QUO_W    = 36;           // quotient magnitude
  localparam int PM_W     = 35;           // clamped projection magnitude
  localparam int SAT_W    = QUO_W + 2;

  localparam logic [PM_W-1:0] PROJ_LIMIT = {1'b1, {(PM_W-1){1'b0}}};

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_PAIR = 1'b1
  } action_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] vel;
  } particle_t;

  typedef struct packed {
    logic [PW-1:0]        p;
    logic [2:0][NW-1:0]   n;
    logic [2:0][VW-1:0]   v;
    logic                 coinc;
  } sqrt_side_t;

  typedef struct packed {
    logic                 psign;
    logic [2:0][NW-1:0]   n;
    logic [2:0][VW-1:0]   v;
    logic                 coinc;
  } div1_side_t;

  typedef struct packed {
    logic                 neg;
    logic [VW-1:0]        v;
    logic                 coinc;
  } div2_side_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [SAT_W-1:0] x);
    logic [COORD_W-1:0] res;
    if (x[SAT_W-1:COORD_W-1] == '0 || x[SAT_W-1:COORD_W-1] == '1) begin
      res = x[COORD_W-1:0];
    end else if (x[SAT_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- hdl/pvs_if.sv -----
interface pvs_in_if import pvs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [SLOT_W-1:0]         frame_slot;
  logic [IDX_W-1:0]          first_particle;
  logic [IDX_W-1:0]          second_particle;
  logic signed [COORD_W-1:0] load_pos_x;
  logic signed [COORD_W-1:0] load_pos_y;
  logic signed [COORD_W-1:0] load_pos_z;
  logic signed [COORD_W-1:0] load_vel_x;
  logic signed [COORD_W-1:0] load_vel_y;
  logic signed [COORD_W-1:0] load_vel_z;

  modport source (
    output valid, action, frame_slot, first_particle, second_particle,
           load_pos_x, load_pos_y, load_pos_z, load_vel_x, load_vel_y, load_vel_z,
    input  ready
  );
  modport sink (
    input  valid, action, frame_slot, first_particle, second_particle,
           load_pos_x, load_pos_y, load_pos_z, load_vel_x, load_vel_y, load_vel_z,
    output ready
  );
endinterface

interface pvs_out_if import pvs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] parallel_x;
  logic signed [COORD_W-1:0] parallel_y;
  logic signed [COORD_W-1:0] parallel_z;
  logic signed [COORD_W-1:0] perpendicular_x;
  logic signed [COORD_W-1:0] perpendicular_y;
  logic signed [COORD_W-1:0] perpendicular_z;
  logic                      coincident;

  modport source (
    output valid, parallel_x, parallel_y, parallel_z,
           perpendicular_x, perpendicular_y, perpendicular_z, coincident,
    input  ready
  );
  modport sink (
    input  valid, parallel_x, parallel_y, parallel_z,
           perpendicular_x, perpendicular_y, perpendicular_z, coincident,
    output ready
  );
endinterface

// ----- hdl/pvs_ram.sv -----
module pvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/pvs_geom.sv -----
module pvs_geom import pvs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  particle_t        pa_i,
  input  particle_t        pb_i,
  input  logic [BOX_W-1:0] box_len_i,
  output logic             valid_o,
  output logic [QW-1:0]    q_o,
  output sqrt_side_t       side_o
);

  localparam int STAGES = 8;
  localparam int TW     = VW + 3;
  localparam int PB_W   = $clog2(UW);

  logic [STAGES-1:0] vld_r;

  logic [2:0][VW-1:0]      dp1_r, dp1_nxt, v1_r, v1_nxt;
  logic [2:0][DW-1:0]      d2_r, d2_nxt;
  logic [2:0][VW-1:0]      v2_r;
  logic [2:0][UW-1:0]      u3_r, u3_nxt;
  logic [2:0]              neg3_r, neg3_nxt;
  logic [2:0][VW-1:0]      v3_r;
  logic [UW-1:0]           m4_nxt, m4_r;
  logic [2:0][UW-1:0]      u4_r;
  logic [2:0]              neg4_r;
  logic [2:0][VW-1:0]      v4_r;
  logic [2:0][UW-1:0]      u5_r;
  logic [2:0]              neg5_r;
  logic [2:0][VW-1:0]      v5_r;
  logic                    rsh5_r, rsh5_nxt, coinc5_r, coinc5_nxt;
  logic [SH_W-1:0]         amt5_r, amt5_nxt;
  logic [2:0][NW-1:0]      n6_r, n6_nxt;
  logic [2:0][VW-1:0]      v6_r;
  logic                    coinc6_r;
  logic [2:0][2*NMW-1:0]   nn7_r, nn7_nxt;
  logic [2:0][VW+NW-1:0]   vn7_r, vn7_nxt;
  logic [2:0][NW-1:0]      n7_r;
  logic [2:0][VW-1:0]      v7_r;
  logic                    coinc7_r;
  logic [QW-1:0]           q8_r, q8_nxt;
  logic [PW-1:0]           p8_nxt;
  sqrt_side_t              side8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], valid_i};
    end
  end

  // Differences of the two stored particles.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp1_nxt[k] = {pa_i.pos[k][COORD_W-1], pa_i.pos[k]} - {pb_i.pos[k][COORD_W-1], pb_i.pos[k]};
      v1_nxt[k]  = {pa_i.vel[k][COORD_W-1], pa_i.vel[k]} - {pb_i.vel[k][COORD_W-1], pb_i.vel[k]};
    end
  end

  // Minimum-image fold: at most one of the two corrections can apply.
  always_comb begin
    logic [TW-1:0] twod;
    logic [TW-1:0] lenx;
    logic [DW-1:0] dx;
    logic [DW-1:0] lx;
    for (int k = 0; k < 3; k++) begin
      twod = {{2{dp1_r[k][VW-1]}}, dp1_r[k], 1'b0};
      lenx = {{(TW-BOX_W){1'b0}}, box_len_i};
      dx   = {{2{dp1_r[k][VW-1]}}, dp1_r[k]};
      lx   = {{(DW-BOX_W){1'b0}}, box_len_i};
      if ($signed(twod) > $signed(lenx)) begin
        d2_nxt[k] = dx - lx;
      end else if ($signed(twod) < -$signed(lenx)) begin
        d2_nxt[k] = dx + lx;
      end else begin
        d2_nxt[k] = dx;
      end
    end
  end

  always_comb begin
    logic [DW-1:0] mg;
    for (int k = 0; k < 3; k++) begin
      neg3_nxt[k] = d2_r[k][DW-1];
      mg          = d2_r[k][DW-1] ? (DW'(0) - d2_r[k]) : d2_r[k];
      u3_nxt[k]   = mg[UW-1:0];
    end
  end

  always_comb begin
    m4_nxt = u3_r[0];
    if (u3_r[1] > m4_nxt) begin
      m4_nxt = u3_r[1];
    end
    if (u3_r[2] > m4_nxt) begin
      m4_nxt = u3_r[2];
    end
  end

  // Common shift that brings the largest magnitude to the target bit.
  always_comb begin
    logic [PB_W-1:0] pos;
    pos = '0;
    for (int b = 0; b < UW; b++) begin
      if (m4_r[b]) begin
        pos = PB_W'(b);
      end
    end
    rsh5_nxt   = pos > PB_W'(NORM_MSB);
    amt5_nxt   = rsh5_nxt ? SH_W'(pos - PB_W'(NORM_MSB)) : SH_W'(PB_W'(NORM_MSB) - pos);
    coinc5_nxt = (m4_r == '0);
  end

  always_comb begin
    logic [UW-1:0]  sh;
    logic [NW-1:0]  nm;
    for (int k = 0; k < 3; k++) begin
      sh        = rsh5_r ? (u5_r[k] >> amt5_r) : (u5_r[k] << amt5_r);
      nm        = {1'b0, sh[NMW-1:0]};
      n6_nxt[k] = neg5_r[k] ? (NW'(0) - nm) : nm;
    end
  end

  always_comb begin
    logic signed [2*NW-1:0] sq;
    for (int k = 0; k < 3; k++) begin
      sq         = $signed(n6_r[k]) * $signed(n6_r[k]);
      nn7_nxt[k] = sq[2*NMW-1:0];
      vn7_nxt[k] = $signed(v6_r[k]) * $signed(n6_r[k]);
    end
  end

  always_comb begin
    q8_nxt = QW'(nn7_r[0]) + QW'(nn7_r[1]) + QW'(nn7_r[2]);
    p8_nxt = PW'($signed(vn7_r[0])) + PW'($signed(vn7_r[1])) + PW'($signed(vn7_r[2]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp1_r    <= dp1_nxt;
      v1_r     <= v1_nxt;
      d2_r     <= d2_nxt;
      v2_r     <= v1_r;
      u3_r     <= u3_nxt;
      neg3_r   <= neg3_nxt;
      v3_r     <= v2_r;
      m4_r     <= m4_nxt;
      u4_r     <= u3_r;
      neg4_r   <= neg3_r;
      v4_r     <= v3_r;
      u5_r     <= u4_r;
      neg5_r   <= neg4_r;
      v5_r     <= v4_r;
      rsh5_r   <= rsh5_nxt;
      amt5_r   <= amt5_nxt;
      coinc5_r <= coinc5_nxt;
      n6_r     <= n6_nxt;
      v6_r     <= v5_r;
      coinc6_r <= coinc5_r;
      nn7_r    <= nn7_nxt;
      vn7_r    <= vn7_nxt;
      n7_r     <= n6_r;
      v7_r     <= v6_r;
      coinc7_r <= coinc6_r;
      q8_r          <= q8_nxt;
      side8_r.p     <= p8_nxt;
      side8_r.n     <= n7_r;
      side8_r.v     <= v7_r;
      side8_r.coinc <= coinc7_r;
    end
  end

  assign valid_o = vld_r[STAGES-1];
  assign q_o     = q8_r;
  assign side_o  = side8_r;

endmodule

// ----- hdl/pvs_sqrt.sv -----
module pvs_sqrt #(
  parameter int QW     = 60,
  parameter int RW     = 30,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [QW-1:0]     q_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int CW = QW + 2;

  logic [RW-1:0]     vld_r;
  logic [QW-1:0]     rem_r    [RW];
  logic [QW-1:0]     rem_nxt  [RW];
  logic [RW-1:0]     root_r   [RW];
  logic [RW-1:0]     root_nxt [RW];
  logic [SIDE_W-1:0] side_r   [RW];

  // One root bit per stage, most significant first; rem holds q - root^2.
  always_comb begin
    logic [QW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [CW-1:0] cand;
    for (int k = 0; k < RW; k++) begin
      rem_in  = (k == 0) ? q_i : rem_r[(k > 0) ? k - 1 : 0];
      root_in = (k == 0) ? '0  : root_r[(k > 0) ? k - 1 : 0];
      cand    = (CW'(root_in) << (RW - k)) + (CW'(1) << (2 * (RW - 1 - k)));
      if ({2'b00, rem_in} >= cand) begin
        rem_nxt[k]  = QW'({2'b00, rem_in} - cand);
        root_nxt[k] = root_in | (RW'(1) << (RW - 1 - k));
      end else begin
        rem_nxt[k]  = rem_in;
        root_nxt[k] = root_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= (k == 0) ? side_i : side_r[(k > 0) ? k - 1 : 0];
      end
    end
  end

  assign valid_o = vld_r[RW-1];
  assign root_o  = root_r[RW-1];
  assign side_o  = side_r[RW-1];

endmodule

// ----- hdl/pvs_div.sv -----
module pvs_div #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 30,
  parameter int QUO_W  = 36,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [QUO_W-1:0]  vld_r;
  logic [DEN_W-1:0]  rem_r   [QUO_W];
  logic [DEN_W-1:0]  rem_nxt [QUO_W];
  logic [QUO_W-1:0]  low_r   [QUO_W];
  logic [QUO_W-1:0]  low_nxt [QUO_W];
  logic [DEN_W-1:0]  den_r   [QUO_W];
  logic [SIDE_W-1:0] side_r  [QUO_W];

  // Restoring division, one quotient bit per stage. The upper dividend bits
  // start as the partial remainder; they are below the divisor for all
  // operands this block produces. Quotient bits shift in behind the
  // remaining dividend bits.
  always_comb begin
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   t;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      rem_in     = (k == 0) ? DEN_W'(num_i >> QUO_W) : rem_r[(k > 0) ? k - 1 : 0];
      low_in     = (k == 0) ? num_i[QUO_W-1:0] : low_r[(k > 0) ? k - 1 : 0];
      den_in     = (k == 0) ? den_i : den_r[(k > 0) ? k - 1 : 0];
      t          = {rem_in, low_in[QUO_W-1]};
      ge         = t >= {1'b0, den_in};
      rem_nxt[k] = ge ? DEN_W'(t - {1'b0, den_in}) : DEN_W'(t);
      low_nxt[k] = {low_in[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        low_r[k]  <= low_nxt[k];
        den_r[k]  <= (k == 0) ? den_i : den_r[(k > 0) ? k - 1 : 0];
        side_r[k] <= (k == 0) ? side_i : side_r[(k > 0) ? k - 1 : 0];
      end
    end
  end

  assign valid_o = vld_r[QUO_W-1];
  assign quo_o   = low_r[QUO_W-1];
  assign den_o   = den_r[QUO_W-1];
  assign side_o  = side_r[QUO_W-1];

endmodule

// ----- hdl/pair_velocity_split_core.sv -----
// Fully pipelined: one transaction is accepted every cycle while the output is not stalled.
// A pair result passes through 1 store read, 8 geometry stages, 30 root stages,
// 36 + 36 divider stages and 5 glue/output stages after its transaction is accepted.
// Load transactions write the particle store in their accept cycle and give no result.
// Synchronous active-low reset clears the pipeline valid bits and sets box_length to 10.0;
// the particle store is not cleared and reads garbage until written.
module pair_velocity_split_core import pvs_pkg::*; #(
  parameter int PARTICLES = PARTICLES_DEF,
  parameter int FRAMES    = FRAMES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [BOX_W-1:0] cfg_wdata,
  pvs_in_if.sink           in_item,
  pvs_out_if.source        out_item
);

  localparam int PI_W  = $clog2(PARTICLES);
  localparam int FI_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int DEPTH = FRAMES * PARTICLES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BOX_W-1:0] box_len_r;
  logic             adv;
  logic             in_acc;
  logic             rd_vld_r;

  logic [PI_W-1:0] part_tab  [1 << IDX_W];
  logic [FI_W-1:0] frame_tab [1 << SLOT_W];
  logic [AW-1:0]   addr_a, addr_b;
  particle_t       wr_part, rd_a, rd_b;

  logic            g_valid;
  logic [QW-1:0]   g_q;
  sqrt_side_t      g_side;

  logic            sq_valid;
  logic [RW-1:0]   sq_root;
  sqrt_side_t      sq_side;

  logic            t1_vld_r;
  logic [NUM_W-1:0] t1_num_r, t1_num_nxt;
  logic [RW-1:0]   t1_den_r;
  div1_side_t      t1_side_r;

  logic            d1_valid;
  logic [QUO_W-1:0] d1_quo;
  logic [RW-1:0]   d1_den;
  div1_side_t      d1_side;

  logic            t2_vld_r;
  logic [PM_W-1:0] t2_pm_r, t2_pm_nxt;
  logic [RW-1:0]   t2_den_r;
  div1_side_t      t2_side_r;

  logic            t3_vld_r;
  logic [2:0][NUM_W-1:0] t3_prod_r, t3_prod_nxt;
  logic [2:0]      t3_neg_r, t3_neg_nxt;
  logic [2:0][VW-1:0] t3_v_r;
  logic            t3_coinc_r;
  logic [RW-1:0]   t3_den_r;

  logic            t4_vld_r;
  logic [NUM_W-1:0] t4_num_r [3];
  logic [RW-1:0]   t4_den_r;
  div2_side_t      t4_side_r [3];

  logic [2:0]      d2_valid;
  logic [QUO_W-1:0] d2_quo [3];
  div2_side_t      d2_side [3];

  logic            out_valid_r;
  logic [2:0][COORD_W-1:0] out_par_r, out_par_nxt, out_perp_r, out_perp_nxt;
  logic            out_coinc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_len_r <= BOX_RESET;
    end else if (cfg_we) begin
      box_len_r <= cfg_wdata;
    end
  end

  // The whole pipeline moves together whenever the output register can take data.
  assign adv           = !out_valid_r || out_item.ready;
  assign in_item.ready = adv;
  assign in_acc        = in_item.valid && adv;

  for (genvar i = 0; i < (1 << IDX_W); i++) begin : g_ptab
    assign part_tab[i] = PI_W'(i % PARTICLES);
  end
  for (genvar i = 0; i < (1 << SLOT_W); i++) begin : g_ftab
    assign frame_tab[i] = FI_W'(i % FRAMES);
  end

  assign addr_a = AW'(int'(frame_tab[in_item.frame_slot]) * PARTICLES
                      + int'(part_tab[in_item.first_particle]));
  assign addr_b = AW'(int'(frame_tab[in_item.frame_slot]) * PARTICLES
                      + int'(part_tab[in_item.second_particle]));

  always_comb begin
    wr_part.pos[0] = in_item.load_pos_x;
    wr_part.pos[1] = in_item.load_pos_y;
    wr_part.pos[2] = in_item.load_pos_z;
    wr_part.vel[0] = in_item.load_vel_x;
    wr_part.vel[1] = in_item.load_vel_y;
    wr_part.vel[2] = in_item.load_vel_z;
  end

  pvs_ram #(
    .WIDTH ($bits(particle_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (in_acc && in_item.action == ACT_LOAD),
    .waddr   (addr_a),
    .wdata   (wr_part),
    .re      (adv),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (adv) begin
      rd_vld_r <= in_acc && in_item.action == ACT_PAIR;
    end
  end

  pvs_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_i   (rd_vld_r),
    .pa_i      (rd_a),
    .pb_i      (rd_b),
    .box_len_i (box_len_r),
    .valid_o   (g_valid),
    .q_o       (g_q),
    .side_o    (g_side)
  );

  pvs_sqrt #(
    .QW     (QW),
    .RW     (RW),
    .SIDE_W ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (g_valid),
    .q_i     (g_q),
    .side_i  (g_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Round to nearest by adding half the divisor to the dividend magnitude.
  always_comb begin
    logic [PW-1:0] pmag;
    pmag       = sq_side.p[PW-1] ? (PW'(0) - sq_side.p) : sq_side.p;
    t1_num_nxt = NUM_W'(pmag) + NUM_W'(sq_root >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_num_r        <= t1_num_nxt;
      t1_den_r        <= sq_root;
      t1_side_r.psign <= sq_side.p[PW-1];
      t1_side_r.n     <= sq_side.n;
      t1_side_r.v     <= sq_side.v;
      t1_side_r.coinc <= sq_side.coinc;
    end
  end

  pvs_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (RW),
    .QUO_W  (QUO_W),
    .SIDE_W ($bits(div1_side_t))
  ) u_div_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (t1_vld_r),
    .num_i   (t1_num_r),
    .den_i   (t1_den_r),
    .side_i  (t1_side_r),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .den_o   (d1_den),
    .side_o  (d1_side)
  );

  assign t2_pm_nxt = (d1_quo > QUO_W'(PROJ_LIMIT)) ? PROJ_LIMIT : d1_quo[PM_W-1:0];

  always_comb begin
    logic [NW-1:0] nm;
    for (int k = 0; k < 3; k++) begin
      nm             = t2_side_r.n[k][NW-1] ? (NW'(0) - t2_side_r.n[k]) : t2_side_r.n[k];
      t3_prod_nxt[k] = NUM_W'(t2_pm_r) * NUM_W'(nm[NMW-1:0]);
      t3_neg_nxt[k]  = t2_side_r.psign ^ t2_side_r.n[k][NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_pm_r    <= t2_pm_nxt;
      t2_den_r   <= d1_den;
      t2_side_r  <= d1_side;
      t3_prod_r  <= t3_prod_nxt;
      t3_neg_r   <= t3_neg_nxt;
      t3_v_r     <= t2_side_r.v;
      t3_coinc_r <= t2_side_r.coinc;
      t3_den_r   <= t2_den_r;
      t4_den_r   <= t3_den_r;
      for (int k = 0; k < 3; k++) begin
        t4_num_r[k]        <= t3_prod_r[k] + NUM_W'(t3_den_r >> 1);
        t4_side_r[k].neg   <= t3_neg_r[k];
        t4_side_r[k].v     <= t3_v_r[k];
        t4_side_r[k].coinc <= t3_coinc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
    end else if (adv) begin
      t1_vld_r <= sq_valid;
      t2_vld_r <= d1_valid;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    pvs_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (RW),
      .QUO_W  (QUO_W),
      .SIDE_W ($bits(div2_side_t))
    ) u_div_par (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (t4_vld_r),
      .num_i   (t4_num_r[k]),
      .den_i   (t4_den_r),
      .side_i  (t4_side_r[k]),
      .valid_o (d2_valid[k]),
      .quo_o   (d2_quo[k]),
      .den_o   (),
      .side_o  (d2_side[k])
    );
  end

  always_comb begin
    logic [SAT_W-1:0] par;
    logic [SAT_W-1:0] vext;
    for (int k = 0; k < 3; k++) begin
      par  = {2'b00, d2_quo[k]};
      par  = d2_side[k].neg ? (SAT_W'(0) - par) : par;
      vext = {{(SAT_W-VW){d2_side[k].v[VW-1]}}, d2_side[k].v};
      if (d2_side[0].coinc) begin
        out_par_nxt[k]  = '0;
        out_perp_nxt[k] = '0;
      end else begin
        out_par_nxt[k]  = sat_coord(par);
        out_perp_nxt[k] = sat_coord(vext - par);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d2_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_par_r   <= out_par_nxt;
      out_perp_r  <= out_perp_nxt;
      out_coinc_r <= d2_side[0].coinc;
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.parallel_x      = out_par_r[0];
  assign out_item.parallel_y      = out_par_r[1];
  assign out_item.parallel_z      = out_par_r[2];
  assign out_item.perpendicular_x = out_perp_r[0];
  assign out_item.perpendicular_y = out_perp_r[1];
  assign out_item.perpendicular_z = out_perp_r[2];
  assign out_item.coincident      = out_coinc_r;

endmodule
